FILE: rtl/core/lba_to_chs_with_range_check_core_assert.svh
// Assertion macros for the LBA to CHS core
`ifndef LBA_TO_CHS_WITH_RANGE_CHECK_CORE_ASSERT_SVH
`define LBA_TO_CHS_WITH_RANGE_CHECK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LCRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcrc assertion failed");
`define LCRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lcrc assertion failed");
`else
`define LCRC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCRC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/lcrc_pkg.sv
// Shared types and constants for the LBA to CHS core
`timescale 1ns / 1ps
package lcrc_pkg;
	localparam int unsigned DivBits = 32;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 48;
	localparam logic [CfgIdxW-1:0] REG_MASTER_GEOM = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SLAVE_GEOM = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MASTER_CAP = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SLAVE_CAP = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LBA_FLAGS = 3'd4;

	typedef struct packed {
		logic [15:0] spt;
		logic [15:0] head;
		logic geo_err;
		logic in_range;
	} side_t;
endpackage

FILE: rtl/core/lcrc_div.sv
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module lcrc_div (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [lcrc_pkg::DivBits-1:0] dividend,
	input logic [lcrc_pkg::DivBits-1:0] divisor,
	input lcrc_pkg::side_t in_side,
	output logic out_valid,
	output logic [lcrc_pkg::DivBits-1:0] quotient,
	output logic [lcrc_pkg::DivBits-1:0] remainder,
	output lcrc_pkg::side_t out_side
);
	localparam int unsigned N = lcrc_pkg::DivBits;

	logic vld_s [0:N];
	logic [N-1:0] num_s [0:N];
	logic [N-1:0] dvs_s [0:N];
	logic [N-1:0] rem_s [0:N];
	logic [N-1:0] quo_s [0:N];
	lcrc_pkg::side_t side_s [0:N];

	assign vld_s[0] = in_valid;
	assign num_s[0] = dividend;
	assign dvs_s[0] = divisor;
	assign rem_s[0] = '0;
	assign quo_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [N:0] trial;
		logic [N:0] diff;
		logic take;
		assign trial = {rem_s[k], num_s[k][N-1]};
		assign diff = trial - {1'b0, dvs_s[k]};
		assign take = (trial >= {1'b0, dvs_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1] <= {num_s[k][N-2:0], 1'b0};
				dvs_s[k+1] <= dvs_s[k];
				rem_s[k+1] <= take ? diff[N-1:0] : trial[N-1:0];
				quo_s[k+1] <= {quo_s[k][N-2:0], take};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign quotient = quo_s[N];
	assign remainder = rem_s[N];
	assign out_side = side_s[N];
endmodule

FILE: rtl/core/lba_to_chs_with_range_check_core.sv
// LBA to CHS conversion with range check, top level
// Input channel: in_valid/in_stall carry lba and use_master. Output channel:
// out_valid/out_stall carry cylinder, head, sector, in_range, geometry_error.
// Drive geometry, capacity and LBA support flags are written via the wr_en/wr_index/
// wr_data port; the user must do this while no transfer is in flight (not enforced).
// An input transfer passes through the registered stages for geometry select,
// products and range compare, then the head divider, the cylinder divider and
// one output register.
// Throughput is one item per cycle while out_stall does not hold a waiting result;
// every stage is a register and the two dividers retire one quotient bit per stage.
// Reset clears all valid bits and the configuration registers.
// While out_stall holds a waiting result the whole pipeline freezes and
// in_stall goes high; nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "lba_to_chs_with_range_check_core_assert.svh"
module lba_to_chs_with_range_check_core (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [lcrc_pkg::CfgIdxW-1:0] wr_index,
	input logic [lcrc_pkg::CfgDataW-1:0] wr_data,
	input logic in_valid,
	output logic in_stall,
	input logic [31:0] lba,
	input logic use_master,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] cylinder,
	output logic [15:0] head,
	output logic [15:0] sector,
	output logic in_range,
	output logic geometry_error
);
	logic [47:0] mgeom_q, sgeom_q;
	logic [31:0] mcap_q, scap_q;
	logic [1:0] flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mgeom_q <= '0;
			sgeom_q <= '0;
			mcap_q <= '0;
			scap_q <= '0;
			flags_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				lcrc_pkg::REG_MASTER_GEOM: mgeom_q <= wr_data;
				lcrc_pkg::REG_SLAVE_GEOM: sgeom_q <= wr_data;
				lcrc_pkg::REG_MASTER_CAP: mcap_q <= wr_data[31:0];
				lcrc_pkg::REG_SLAVE_CAP: scap_q <= wr_data[31:0];
				lcrc_pkg::REG_LBA_FLAGS: flags_q <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	logic [47:0] geom_sel;
	assign geom_sel = use_master ? mgeom_q : sgeom_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [31:0] lba_s1, lba_s2, lba_s3, lba_s4;
	logic [15:0] spt_s1, spt_s2, spt_s3, spt_s4;
	logic [15:0] cyls_s1, cyls_s2, heads_s1;
	logic [31:0] cap_s1, cap_s2;
	logic ok_s1, ok_s2;
	logic [31:0] surf_s2, surf_s3, surf_s4, sh_s2, max_s3;
	logic inr_s4, gerr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lba_s1 <= lba;
			spt_s1 <= geom_sel[15:0];
			cyls_s1 <= geom_sel[31:16];
			heads_s1 <= geom_sel[47:32];
			cap_s1 <= use_master ? mcap_q : scap_q;
			ok_s1 <= use_master ? flags_q[0] : flags_q[1];

			lba_s2 <= lba_s1;
			spt_s2 <= spt_s1;
			cyls_s2 <= cyls_s1;
			cap_s2 <= cap_s1;
			ok_s2 <= ok_s1;
			surf_s2 <= 32'(spt_s1 * cyls_s1);
			sh_s2 <= 32'(spt_s1 * heads_s1);

			lba_s3 <= lba_s2;
			spt_s3 <= spt_s2;
			surf_s3 <= surf_s2;
			max_s3 <= ok_s2 ? cap_s2 : 32'(sh_s2 * cyls_s2);

			lba_s4 <= lba_s3;
			spt_s4 <= spt_s3;
			surf_s4 <= surf_s3;
			inr_s4 <= (lba_s3 < max_s3);
			gerr_s4 <= (surf_s3 == 32'd0) || (spt_s3 == 16'd0);
		end
	end

	lcrc_pkg::side_t side_a, side_b, side_c, side_d;
	logic va, vb;
	logic [31:0] qa, ra, qb, rb;

	always_comb begin
		side_a = '0;
		side_a.spt = spt_s4;
		side_a.geo_err = gerr_s4;
		side_a.in_range = inr_s4;
	end

	lcrc_div u_div_head (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .dividend(lba_s4), .divisor(surf_s4), .in_side(side_a),
		.out_valid(va), .quotient(qa), .remainder(ra), .out_side(side_b)
	);

	always_comb begin
		side_c = side_b;
		side_c.head = qa[15:0];
	end

	lcrc_div u_div_cyl (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(va), .dividend(ra), .divisor({16'd0, side_b.spt}), .in_side(side_c),
		.out_valid(vb), .quotient(qb), .remainder(rb), .out_side(side_d)
	);

	logic out_valid_q;
	logic [15:0] cyl_q, head_q, sec_q;
	logic inr_q, gerr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cyl_q <= side_d.geo_err ? 16'd0 : qb[15:0];
			head_q <= side_d.geo_err ? 16'd0 : side_d.head;
			sec_q <= side_d.geo_err ? 16'd0 : 16'(rb[15:0] + 16'd1);
			inr_q <= side_d.in_range;
			gerr_q <= side_d.geo_err;
		end
	end

	assign out_valid = out_valid_q;
	assign cylinder = cyl_q;
	assign head = head_q;
	assign sector = sec_q;
	assign in_range = inr_q;
	assign geometry_error = gerr_q;

	`LCRC_ASSERT_IMP(a_gerr_zero, clk, arst_n, out_valid && geometry_error, (cylinder == 16'd0) && (head == 16'd0) && (sector == 16'd0))
	`LCRC_ASSERT_IMP(a_sec_nonzero, clk, arst_n, out_valid && !geometry_error, sector != 16'd0)
	`LCRC_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	`LCRC_ASSERT_NXT(a_freeze, clk, arst_n, out_valid && out_stall, $stable(v_s4) && $stable(lba_s4))
endmodule

FILE: tb/sv/lba_to_chs_with_range_check_core_test.sv
// Self-checking testbench for the LBA to CHS core: table-driven directed transfers, then random ones
`timescale 1ns / 1ps
module lba_to_chs_with_range_check_core_test;
	localparam int LATENCY = 69;
	localparam int RANDOM_ITEMS = 380;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [15:0] cyl;
		logic [15:0] hd;
		logic [15:0] sec;
		logic rng;
		logic gerr;
	} chs_t;

	typedef struct {
		logic [31:0] lba;
		logic master;
		logic typed;
		chs_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [lcrc_pkg::CfgIdxW-1:0] wr_index = '0;
	logic [lcrc_pkg::CfgDataW-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] lba = '0;
	logic use_master = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] cylinder, head, sector;
	logic in_range, geometry_error;

	logic [47:0] geom_m, geom_s;
	logic [31:0] cap_m, cap_s;
	logic [1:0] lba_flags;

	chs_t chs_queue[$];
	int failures = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;
	bit stall_random = 1'b1;

	lba_to_chs_with_range_check_core uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic chs_t convert(logic [31:0] a, logic m);
		chs_t r;
		logic [47:0] g;
		logic [31:0] spt, cyls, heads, surface, rem, maxsec;
		logic [63:0] p;
		logic ok;
		g = m ? geom_m : geom_s;
		ok = m ? lba_flags[0] : lba_flags[1];
		spt = {16'd0, g[15:0]};
		cyls = {16'd0, g[31:16]};
		heads = {16'd0, g[47:32]};
		p = spt * cyls;
		surface = p[31:0];
		r = '{default: '0};
		r.gerr = (surface == 0) || (spt == 0);
		if (!r.gerr) begin
			rem = a % surface;
			r.hd = 16'(a / surface);
			r.cyl = 16'(rem / spt);
			r.sec = 16'((rem % spt) + 1);
		end
		if (ok) begin
			maxsec = m ? cap_m : cap_s;
		end else begin
			p = {32'd0, 32'(spt * heads)} * {32'd0, cyls};
			maxsec = p[31:0];
		end
		r.rng = a < maxsec;
		return r;
	endfunction

	task automatic write_reg(logic [lcrc_pkg::CfgIdxW-1:0] idx, logic [47:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			lcrc_pkg::REG_MASTER_GEOM: geom_m = val;
			lcrc_pkg::REG_SLAVE_GEOM: geom_s = val;
			lcrc_pkg::REG_MASTER_CAP: cap_m = val[31:0];
			lcrc_pkg::REG_SLAVE_CAP: cap_s = val[31:0];
			lcrc_pkg::REG_LBA_FLAGS: lba_flags = val[1:0];
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain();
		wait (chs_queue.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// hold until accepted; valid stays high if another transfer follows
	task automatic send(logic [31:0] a, logic m, bit more);
		in_valid <= 1'b1;
		lba <= a;
		use_master <= m;
		do @(posedge clk); while (in_stall);
		chs_queue.push_back(convert(a, m));
		if (!more) in_valid <= 1'b0;
	endtask

	task automatic random_config();
		logic [15:0] s, c, h;
		s = ($urandom_range(0, 9) == 0) ? 16'd0 :
			($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 80));
		c = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2000));
		h = 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 16));
		write_reg(lcrc_pkg::REG_MASTER_GEOM, {h, c, s});
		write_reg(lcrc_pkg::REG_SLAVE_GEOM, {16'($urandom), 16'($urandom_range(0, 300)),
			16'($urandom_range(0, 64))});
		write_reg(lcrc_pkg::REG_MASTER_CAP, 48'($urandom));
		write_reg(lcrc_pkg::REG_SLAVE_CAP,
			48'($urandom_range(0, 3) == 0 ? 32'hffff_ffff : $urandom));
		write_reg(lcrc_pkg::REG_LBA_FLAGS, 48'($urandom_range(0, 3)));
	endtask

	function automatic logic [31:0] random_lba();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1000);
			2: return 32'hffff_ffff - $urandom_range(0, 100);
			default: return $urandom_range(0, 2000000);
		endcase
	endfunction

	// receiver pattern: random stalls, a no-stall phase, and a long hold-off
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (hold_off) out_stall <= 1'b1;
		else if (stall_random) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= 1'b0;
	end

	always @(posedge clk) begin
		chs_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (chs_queue.size() == 0) begin
				$error("unexpected transfer");
				failures++;
			end else begin
				w = chs_queue.pop_front();
				if (cylinder !== w.cyl) begin
					$error("cylinder exp %0d got %0d", w.cyl, cylinder);
					failures++;
				end
				if (head !== w.hd) begin
					$error("head exp %0d got %0d", w.hd, head);
					failures++;
				end
				if (sector !== w.sec) begin
					$error("sector exp %0d got %0d", w.sec, sector);
					failures++;
				end
				if (in_range !== w.rng) begin
					$error("in_range exp %0d got %0d", w.rng, in_range);
					failures++;
				end
				if (geometry_error !== w.gerr) begin
					$error("geometry_error exp %0d got %0d", w.gerr, geometry_error);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	stim_row_t directed[] = '{
		// after reset: zero geometry
		'{32'd0, 1'b1, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0, 1'b1}},
		'{32'hffff_ffff, 1'b0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0, 1'b1}},
		// 63 spt, 1024 cyl, 16 heads on master; slave LBA capacity max
		'{32'd0, 1'b1, 1'b1, '{16'd0, 16'd0, 16'd1, 1'b1, 1'b0}},
		'{32'd62, 1'b1, 1'b1, '{16'd0, 16'd0, 16'd63, 1'b1, 1'b0}},
		'{32'd63, 1'b1, 1'b1, '{16'd1, 16'd0, 16'd1, 1'b1, 1'b0}},
		'{32'd64511, 1'b1, 1'b1, '{16'd1023, 16'd0, 16'd63, 1'b1, 1'b0}},
		'{32'd64512, 1'b1, 1'b1, '{16'd0, 16'd1, 16'd1, 1'b1, 1'b0}},
		'{32'd1032191, 1'b1, 1'b0, '{default: '0}},
		'{32'd1032192, 1'b1, 1'b0, '{default: '0}},
		'{32'hffff_ffff, 1'b1, 1'b0, '{default: '0}},
		'{32'hffff_fffe, 1'b0, 1'b0, '{default: '0}},
		'{32'hffff_ffff, 1'b0, 1'b0, '{default: '0}},
		'{32'h8000_0000, 1'b0, 1'b0, '{default: '0}},
		'{32'd12345, 1'b0, 1'b0, '{default: '0}}
	};

	initial begin
		stim_row_t row;
		chs_t got;
		int n, gap, idle;
		geom_m = '0; geom_s = '0; cap_m = '0; cap_s = '0; lba_flags = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < $size(directed); i++) begin
			if (i == 2) begin
				drain();
				write_reg(lcrc_pkg::REG_MASTER_GEOM, {16'd16, 16'd1024, 16'd63});
				write_reg(lcrc_pkg::REG_SLAVE_GEOM, {16'd1, 16'd1, 16'd1});
				write_reg(lcrc_pkg::REG_MASTER_CAP, 48'd0);
				write_reg(lcrc_pkg::REG_SLAVE_CAP, 48'hffff_ffff);
				write_reg(lcrc_pkg::REG_LBA_FLAGS, 48'd2);
			end
			row = directed[i];
			if (row.typed) begin
				got = convert(row.lba, row.master);
				if (got != row.want) begin
					$error("directed row %0d: predictor disagrees with table", i);
					failures++;
				end
			end
			send(row.lba, row.master, i != 1 && i != $size(directed) - 1);
		end
		// master fields at max, slave heads at max: head overflow and wrapped products
		drain();
		write_reg(lcrc_pkg::REG_MASTER_GEOM, 48'hffff_ffff_ffff);
		write_reg(lcrc_pkg::REG_SLAVE_GEOM, {16'hffff, 16'd1, 16'd1});
		write_reg(lcrc_pkg::REG_LBA_FLAGS, 48'd0);
		send(32'hffff_ffff, 1'b1, 1'b1);
		send(32'hfffe_0000, 1'b1, 1'b1);
		send(32'hffff_ffff, 1'b0, 1'b1);
		send(32'h0001_0000, 1'b0, 1'b0);
		// long hold-off: block fills and stalls its input
		drain();
		hold_off = 1'b1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 120; i++) send(random_lba(), 1'($urandom), i != 119);
		join
		n = 0;
		while (n < RANDOM_ITEMS) begin
			drain();
			random_config();
			stall_random = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < 100 && n < RANDOM_ITEMS; ) begin
				gap = $urandom_range(1, 12);
				for (int b = 0; b < gap && k < 100 && n < RANDOM_ITEMS; b++) begin
					send(random_lba(), 1'($urandom), 1'b1);
					k++;
					n++;
				end
				idle = (k < 100 && n < RANDOM_ITEMS) ? $urandom_range(0, 6) : 1;
				if (idle != 0) begin
					in_valid <= 1'b0;
					repeat (idle) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
		stall_random = 1'b1;
		drain();
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
